// ===== src/assert_macros.svh =====
// assertion macros for the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// next-cycle implication outside reset
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

// ===== src/asei_pkg.sv =====
// shared types, constants and tables of the arc interpolator
// no dependencies
package asei_pkg;

   localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIV, ST_CORDIC, ST_MUL, ST_EMIT
   } state_type;

   typedef struct packed {
      logic signed [31:0] centre_x;
      logic signed [31:0] centre_y;
      logic signed [31:0] centre_z;
      logic signed [31:0] radius_x;
      logic signed [31:0] radius_y;
      logic signed [31:0] angle_origin;
      logic signed [31:0] sweep_angle;
      logic [5:0]         segment_count;
      logic signed [31:0] radius_delta;
      logic signed [31:0] height_delta;
   } req_type;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic               last_point;
   } rsp_type;

   // cordic unit control
   typedef struct packed {
      logic        start;
      logic [31:0] angle;
   } cordic_ctl_type;

   typedef struct packed {
      logic               done;
      logic signed [31:0] cos_q30;
      logic signed [31:0] sin_q30;
   } cordic_sts_type;

   // atan(2^-i) in units of 2^-32 turn
   function automatic logic [29:0] atan_lookup(input logic [4:0] i);
      logic [29:0] r;
      begin
         case (i)
            5'd0: r = 30'd536870912;  5'd1: r = 30'd316933406;
            5'd2: r = 30'd167458907;  5'd3: r = 30'd85004756;
            5'd4: r = 30'd42667331;   5'd5: r = 30'd21354465;
            5'd6: r = 30'd10679838;   5'd7: r = 30'd5340245;
            5'd8: r = 30'd2670163;    5'd9: r = 30'd1335087;
            5'd10: r = 30'd667544;    5'd11: r = 30'd333772;
            5'd12: r = 30'd166886;    5'd13: r = 30'd83443;
            5'd14: r = 30'd41722;     5'd15: r = 30'd20861;
            5'd16: r = 30'd10430;     5'd17: r = 30'd5215;
            5'd18: r = 30'd2608;      5'd19: r = 30'd1304;
            5'd20: r = 30'd652;       5'd21: r = 30'd326;
            5'd22: r = 30'd163;       5'd23: r = 30'd81;
            5'd24: r = 30'd41;        5'd25: r = 30'd20;
            5'd26: r = 30'd10;        5'd27: r = 30'd5;
            5'd28: r = 30'd3;         5'd29: r = 30'd1;
            5'd30: r = 30'd1;
            default: r = 30'd0;
         endcase
         return r;
      end
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      begin
         if (v > 34'sd2147483647) return 32'sh7fffffff;
         else if (v < -34'sd2147483648) return 32'sh80000000;
         else return v[31:0];
      end
   endfunction

endpackage

// ===== src/asei_stream_if.sv =====
// valid/ready channel carrying one payload beat
// depends on nothing but the payload type parameter
interface asei_stream_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== src/asei_cordic.sv =====
// iterative rotation-mode cordic, one micro-rotation per cycle
// depends on asei_pkg
module asei_cordic #(
   parameter int unsigned ITERATIONS = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   input  asei_pkg::cordic_ctl_type        ctl,
   output asei_pkg::cordic_sts_type        sts
);
   localparam int unsigned IW = $clog2(ITERATIONS + 1);

   logic signed [33:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [1:0]         quad_ff, quad_in;
   logic [IW-1:0]      iter_ff, iter_in;
   logic               busy_ff, busy_in, done_ff, done_in;
   logic signed [33:0] dx, dy, at;

   always_comb begin
      x_in = x_ff; y_in = y_ff; z_in = z_ff; quad_in = quad_ff;
      iter_in = iter_ff; busy_in = busy_ff; done_in = 1'b0;
      dx = y_ff >>> iter_ff;
      dy = x_ff >>> iter_ff;
      at = 34'(asei_pkg::atan_lookup(5'(iter_ff)));
      if (ctl.start) begin
         x_in = 34'(asei_pkg::GAIN_Q30);
         y_in = '0;
         z_in = {4'b0, ctl.angle[21:0], 8'b0};
         quad_in = ctl.angle[23:22];
         iter_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[33]) begin
            x_in = x_ff - dx; y_in = y_ff + dy; z_in = z_ff - at;
         end else begin
            x_in = x_ff + dx; y_in = y_ff - dy; z_in = z_ff + at;
         end
         iter_in = iter_ff + 1'b1;
         if (iter_ff == IW'(ITERATIONS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in;
      quad_ff <= quad_in; iter_ff <= iter_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_comb begin
      sts.done = done_ff;
      case (quad_ff)
         2'd0: begin sts.cos_q30 = x_ff[31:0]; sts.sin_q30 = y_ff[31:0]; end
         2'd1: begin sts.cos_q30 = -y_ff[31:0]; sts.sin_q30 = x_ff[31:0]; end
         2'd2: begin sts.cos_q30 = -x_ff[31:0]; sts.sin_q30 = -y_ff[31:0]; end
         default: begin sts.cos_q30 = y_ff[31:0]; sts.sin_q30 = -x_ff[31:0]; end
      endcase
   end
endmodule

// ===== src/asei_divider.sv =====
// shared restoring divider, signed 32-bit by 6-bit count, one quotient bit a cycle
// depends on nothing
module asei_divider (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] dividend,
   input  logic [5:0]         divisor,
   output logic               done,
   output logic signed [31:0] quotient
);
   logic [31:0] mag_ff, mag_in, q_ff, q_in;
   logic [6:0]  rem_ff, rem_in;
   logic [5:0]  dv_ff, dv_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        neg_ff, neg_in, busy_ff, busy_in, done_ff, done_in;
   logic [6:0]  trial;

   always_comb begin
      mag_in = mag_ff; q_in = q_ff; rem_in = rem_ff; dv_in = dv_ff;
      cnt_in = cnt_ff; neg_in = neg_ff; busy_in = busy_ff; done_in = 1'b0;
      trial = {rem_ff[5:0], mag_ff[31]};
      if (start) begin
         mag_in = dividend[31] ? 32'(-dividend) : dividend;
         neg_in = dividend[31];
         dv_in = divisor;
         rem_in = '0;
         q_in = '0;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         mag_in = {mag_ff[30:0], 1'b0};
         if (trial >= {1'b0, dv_ff}) begin
            rem_in = trial - {1'b0, dv_ff};
            q_in = {q_ff[30:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in = {q_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in; q_ff <= q_in; rem_ff <= rem_in; dv_ff <= dv_in;
      cnt_ff <= cnt_in; neg_ff <= neg_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quotient = neg_ff ? -q_ff : q_ff;
endmodule

// ===== src/arc_spiral_ellipse_interpolator_top.sv =====
// top level of the arc interpolator: sequencer, accumulators, shared multiplier
// depends on asei_pkg, asei_stream_if, asei_divider, asei_cordic
//
// One request beat carries an arc command; the block answers with
// segment_count+1 point beats (none for a zero count), the last one flagged.
// The request side is not ready while a command is in progress. Per command
// three divisions (sweep angle, radius delta, height delta) run first, one
// after another on the one shared divider; then each point takes one CORDIC
// pass, a multiply for x and then for y, and an output step that waits while
// the previous point beat is not yet taken. The angle wraps; radii and height
// saturate each step; coordinates saturate to COORD_WIDTH bits (at most 32).
module arc_spiral_ellipse_interpolator_top #(
   parameter int unsigned MAX_SEGMENTS      = 63,
   parameter int unsigned COORD_WIDTH       = 32,
   parameter int unsigned CORDIC_ITERATIONS = 24
) (
   input logic                      clock,
   input logic                      reset,
   asei_stream_if.sink              req,
   asei_stream_if.source            rsp
);
   localparam int unsigned OW = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;
   localparam logic signed [33:0] SAT_HI = 34'sd2147483647 >>> (32 - OW);
   localparam logic signed [33:0] SAT_LO = -SAT_HI - 34'sd1;

   asei_pkg::state_type state_ff, state_in;
   asei_pkg::req_type   cmd_ff, cmd_in;
   logic [31:0]         angle_ff, angle_in;
   logic signed [31:0]  rx_ff, rx_in, ry_ff, ry_in, hz_ff, hz_in;
   logic signed [31:0]  astep_ff, astep_in, rstep_ff, rstep_in, hstep_ff, hstep_in;
   logic [6:0]          count_ff, count_in;
   logic [5:0]          nseg_ff, nseg_in;
   logic [1:0]          dsel_ff, dsel_in;
   logic                mphase_ff, mphase_in;
   logic signed [33:0]  px_ff, px_in, py_ff, py_in;
   asei_pkg::rsp_type   out_ff, out_in;
   logic                ov_ff, ov_in;

   // shared units
   logic                div_start, div_done;
   logic signed [31:0]  div_dividend, div_q;
   asei_pkg::cordic_ctl_type cctl;
   asei_pkg::cordic_sts_type csts;

   // one shared 32x32 multiplier used for x then y
   logic signed [31:0]  mul_a, mul_b;
   logic signed [63:0]  mul_p;
   logic signed [33:0]  mul_r;

   asei_divider u_div (
      .clock, .reset, .start(div_start), .dividend(div_dividend),
      .divisor(nseg_ff), .done(div_done), .quotient(div_q)
   );

   asei_cordic #(.ITERATIONS(CORDIC_ITERATIONS)) u_cordic (
      .clock, .reset, .ctl(cctl), .sts(csts)
   );

   function automatic logic signed [31:0] sat_out(input logic signed [33:0] v);
      begin
         if (v > SAT_HI) return SAT_HI[31:0];
         else if (v < SAT_LO) return SAT_LO[31:0];
         else return v[31:0];
      end
   endfunction

   always_comb begin
      mul_a = mphase_ff ? ry_ff : rx_ff;
      mul_b = mphase_ff ? csts.sin_q30 : csts.cos_q30;
      mul_p = mul_a * mul_b + 64'sd536870912;
      mul_r = 34'(mul_p >>> 30);
   end

   always_comb begin
      state_in = state_ff; cmd_in = cmd_ff; angle_in = angle_ff;
      rx_in = rx_ff; ry_in = ry_ff; hz_in = hz_ff;
      astep_in = astep_ff; rstep_in = rstep_ff; hstep_in = hstep_ff;
      count_in = count_ff; nseg_in = nseg_ff; dsel_in = dsel_ff;
      mphase_in = mphase_ff; px_in = px_ff; py_in = py_ff;
      out_in = out_ff; ov_in = ov_ff;
      div_start = 1'b0;
      div_dividend = cmd_ff.sweep_angle;
      cctl.start = 1'b0;
      cctl.angle = angle_ff;
      req.ready = (state_ff == asei_pkg::ST_IDLE) && !ov_ff;
      if (rsp.ready) ov_in = 1'b0;
      case (dsel_ff)
         2'd1: div_dividend = cmd_ff.radius_delta;
         2'd2: div_dividend = cmd_ff.height_delta;
         default: div_dividend = cmd_ff.sweep_angle;
      endcase
      case (state_ff)
         asei_pkg::ST_IDLE: begin
            if (req.valid && req.ready) begin
               cmd_in = req.data;
               angle_in = req.data.angle_origin;
               rx_in = req.data.radius_x;
               ry_in = req.data.radius_y;
               hz_in = req.data.centre_z;
               count_in = '0;
               nseg_in = (32'(req.data.segment_count) > MAX_SEGMENTS) ?
                  6'(MAX_SEGMENTS) : req.data.segment_count;
               dsel_in = 2'd0;
               if (req.data.segment_count != 6'd0) state_in = asei_pkg::ST_DIV;
            end
         end
         asei_pkg::ST_DIV: begin
            if (div_done) begin
               case (dsel_ff)
                  2'd0: astep_in = div_q;
                  2'd1: rstep_in = div_q;
                  default: hstep_in = div_q;
               endcase
               if (dsel_ff == 2'd2) begin
                  state_in = asei_pkg::ST_CORDIC;
                  cctl.start = 1'b1;
               end else begin
                  dsel_in = dsel_ff + 2'd1;
                  div_start = 1'b1;
                  case (dsel_ff)
                     2'd0: div_dividend = cmd_ff.radius_delta;
                     default: div_dividend = cmd_ff.height_delta;
                  endcase
               end
            end else if (dsel_ff == 2'd0 && count_ff == 7'd0 && !mphase_ff) begin
               div_start = 1'b1;
               mphase_in = 1'b1;
            end
         end
         asei_pkg::ST_CORDIC: begin
            mphase_in = 1'b0;
            if (csts.done) state_in = asei_pkg::ST_MUL;
         end
         asei_pkg::ST_MUL: begin
            if (!mphase_ff) begin
               px_in = 34'(cmd_ff.centre_x) + mul_r;
               mphase_in = 1'b1;
            end else begin
               py_in = 34'(cmd_ff.centre_y) + mul_r;
               mphase_in = 1'b0;
               state_in = asei_pkg::ST_EMIT;
            end
         end
         asei_pkg::ST_EMIT: begin
            if (!ov_ff || rsp.ready) begin
               out_in.point_x = sat_out(px_ff);
               out_in.point_y = sat_out(py_ff);
               out_in.point_z = sat_out(34'(hz_ff));
               out_in.last_point = (count_ff == {1'b0, nseg_ff});
               ov_in = 1'b1;
               angle_in = angle_ff + astep_ff;
               rx_in = asei_pkg::sat32(34'(rx_ff) + 34'(rstep_ff));
               ry_in = asei_pkg::sat32(34'(ry_ff) + 34'(rstep_ff));
               hz_in = asei_pkg::sat32(34'(hz_ff) + 34'(hstep_ff));
               count_in = count_ff + 7'd1;
               if (count_ff == {1'b0, nseg_ff}) begin
                  state_in = asei_pkg::ST_IDLE;
               end else begin
                  state_in = asei_pkg::ST_CORDIC;
                  cctl.start = 1'b1;
                  cctl.angle = angle_ff + astep_ff;
               end
            end
         end
         default: state_in = asei_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in; angle_ff <= angle_in;
      rx_ff <= rx_in; ry_ff <= ry_in; hz_ff <= hz_in;
      astep_ff <= astep_in; rstep_ff <= rstep_in; hstep_ff <= hstep_in;
      nseg_ff <= nseg_in; dsel_ff <= dsel_in;
      px_ff <= px_in; py_ff <= py_in; out_ff <= out_in;
      if (reset) begin
         state_ff <= asei_pkg::ST_IDLE;
         ov_ff <= 1'b0;
         count_ff <= '0;
         mphase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ov_ff <= ov_in;
         count_ff <= count_in;
         mphase_ff <= mphase_in;
      end
   end

   assign rsp.valid = ov_ff;
   assign rsp.data = out_ff;
endmodule

// ===== src/asei_checker.sv =====
// port-level checks on the arc interpolator, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"
module asei_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_last
);
   // a held beat keeps valid
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   // no new command taken while a point beat waits
   `ASSERT_IMPL(a_no_req_on_rsp, clock, reset, rsp_valid, !req_ready)
   // a command accept is followed by no point beat in the next cycle
   `ASSERT_NEXT(a_req_close, clock, reset, req_valid && req_ready, !rsp_valid)
   // after the last point is taken nothing more follows at once
   `ASSERT_NEXT(a_last_end, clock, reset, rsp_valid && rsp_ready && rsp_last,
      !rsp_valid)
endmodule

bind arc_spiral_ellipse_interpolator_top asei_checker u_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_last(rsp.data.last_point)
);

// ===== dv/tb_arc_spiral_ellipse_interpolator_top.sv =====
// self-checking testbench of the arc interpolator: random arc commands, point checks
// depends on asei_pkg, asei_stream_if and arc_spiral_ellipse_interpolator_top
`timescale 1ns / 100ps
module tb_arc_spiral_ellipse_interpolator_top;

   localparam int unsigned MAX_SEG     = 63;
   localparam int unsigned ITERS       = 24;
   localparam int unsigned N_RAND      = 240;
   localparam int unsigned N_BURST     = 24;
   localparam int unsigned HOLD_CYCLES = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #6 clock = ~clock;

   asei_stream_if #(.payload_type(asei_pkg::req_type)) req (.clock(clock));
   asei_stream_if #(.payload_type(asei_pkg::rsp_type)) rsp (.clock(clock));

   arc_spiral_ellipse_interpolator_top u_dut (
      .clock(clock),
      .reset(reset),
      .req  (req),
      .rsp  (rsp)
   );

   // commands waiting to be driven, and points still owed by the block
   asei_pkg::req_type pending_cmds[$];
   asei_pkg::rsp_type expected_points[$];
   int      error_count = 0;
   bit      stim_done = 1'b0;
   bit      no_idle = 1'b0;    // burst stretch: neither side idles but for the receiver hold-off
   bit      hold_rx = 1'b0;    // long receiver hold-off, timed by its own process

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // arithmetic shift right with floor, as the hardware shifts
   function automatic longint floor_shift(input longint v, input int s);
      return v >>> s;
   endfunction

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // rotation-mode cordic over one quadrant, then mapped to the full turn
   task automatic trig_of(input logic [31:0] angle, output longint c, output longint s);
      longint x, y, z, dx, dy;
      logic [1:0] quad;
      x = 652032874;
      y = 0;
      quad = angle[23:22];
      z = longint'({angle[21:0], 8'h00});
      for (int i = 0; i < ITERS; i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(asei_pkg::atan_lookup(i[4:0]));
         end else begin
            x += dx; y -= dy; z += longint'(asei_pkg::atan_lookup(i[4:0]));
         end
      end
      case (quad)
         2'd0: begin c = x;  s = y;  end
         2'd1: begin c = -y; s = x;  end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endtask

   // expands one arc command into the points it should produce
   task automatic predict_arc_points(input asei_pkg::req_type cmd);
      logic [31:0] ang;
      longint rx, ry, hz, n, astep, rstep, hstep, c, s;
      asei_pkg::rsp_type p;
      ang = cmd.angle_origin;
      rx = cmd.radius_x;
      ry = cmd.radius_y;
      hz = cmd.centre_z;
      n = cmd.segment_count;
      if (n > MAX_SEG) n = MAX_SEG;
      if (n == 0) return;
      // longint division truncates toward zero
      astep = longint'(cmd.sweep_angle) / n;
      rstep = longint'(cmd.radius_delta) / n;
      hstep = longint'(cmd.height_delta) / n;
      for (longint k = 0; k <= n; k++) begin
         trig_of(ang, c, s);
         p.point_x = 32'(clamp32(longint'(cmd.centre_x) + floor_shift(rx * c + (64'sd1 << 29), 30)));
         p.point_y = 32'(clamp32(longint'(cmd.centre_y) + floor_shift(ry * s + (64'sd1 << 29), 30)));
         p.point_z = 32'(clamp32(hz));
         p.last_point = (k == n);
         expected_points.push_back(p);
         ang = ang + 32'(astep);
         rx = clamp32(rx + rstep);
         ry = clamp32(ry + rstep);
         hz = clamp32(hz + hstep);
      end
   endtask

   function automatic logic [31:0] rand_word(input int kind);
      case (kind)
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'(int'($urandom_range(0, 2000)) - 1000);
         3: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   function automatic asei_pkg::req_type rand_cmd();
      asei_pkg::req_type c;
      int shape;
      shape = $urandom_range(0, 9);
      c.centre_x = rand_word($urandom_range(0, 4));
      c.centre_y = rand_word($urandom_range(0, 4));
      c.centre_z = rand_word($urandom_range(0, 4));
      c.radius_x = rand_word($urandom_range(2, 4));
      c.radius_y = (shape < 3) ? c.radius_x : rand_word($urandom_range(0, 4));
      c.angle_origin = $urandom;
      c.sweep_angle = rand_word($urandom_range(2, 4));
      // mostly short arcs, now and then a long one
      c.segment_count = ($urandom_range(0, 15) == 0) ? 6'($urandom_range(32, 63))
                                                     : 6'($urandom_range(0, 8));
      // circles and ellipses have no change, spirals and helices do
      c.radius_delta = (shape < 6) ? 32'd0 : rand_word($urandom_range(0, 4));
      c.height_delta = (shape < 6) ? 32'd0 : rand_word($urandom_range(0, 4));
      return c;
   endfunction

   // driver: offers the head of the queue, idling about a quarter of the time
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req.data  <= '0;
      end else if (!req.valid || req.ready) begin
         if (pending_cmds.size() > 0 && (no_idle || $urandom_range(0, 99) >= 26)) begin
            req.valid <= 1'b1;
            req.data  <= pending_cmds.pop_front();
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // predict on acceptance of a command beat
   always @(posedge clock) begin
      if (!reset && req.valid && req.ready) predict_arc_points(req.data);
   end

   // monitor: checks each point beat, drives ready with random stalls
   always @(posedge clock) begin
      asei_pkg::rsp_type want;
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_points.size() == 0) begin
               report_mismatch("unexpected point", rsp.data.point_x, 32'h0);
            end else begin
               want = expected_points.pop_front();
               if (rsp.data.point_x !== want.point_x)
                  report_mismatch("point_x", rsp.data.point_x, want.point_x);
               if (rsp.data.point_y !== want.point_y)
                  report_mismatch("point_y", rsp.data.point_y, want.point_y);
               if (rsp.data.point_z !== want.point_z)
                  report_mismatch("point_z", rsp.data.point_z, want.point_z);
               if (rsp.data.last_point !== want.last_point)
                  report_mismatch("last_point", 32'(rsp.data.last_point),
                                  32'(want.last_point));
            end
         end
         if (hold_rx) begin
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= no_idle || ($urandom_range(0, 99) >= 26);
         end
      end
   end

   // receiver hold-off at the start of the burst, long enough to stall the request side
   initial begin
      wait (no_idle);
      @(posedge clock);
      hold_rx <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rx <= 1'b0;
   end

   // stimulus: directed corners first, then random arcs
   initial begin
      asei_pkg::req_type c;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // plain circle, one segment, quarter turn
      c = '0;
      c.radius_x = 32'h0001_0000; c.radius_y = 32'h0001_0000;
      c.sweep_angle = 32'h0040_0000; c.segment_count = 6'd1;
      pending_cmds.push_back(c);
      // zero segments: no points at all
      c.segment_count = 6'd0;
      pending_cmds.push_back(c);
      // every quadrant of the start angle, negative sweep
      for (int q = 0; q < 4; q++) begin
         c = '0;
         c.radius_x = 32'h0010_0000; c.radius_y = 32'h0008_0000;
         c.angle_origin = 32'(q) << 22 | 32'h0001_2345;
         c.sweep_angle = -32'sd3000000; c.segment_count = 6'd3;
         pending_cmds.push_back(c);
      end
      // field extremes: saturating coordinates and accumulators
      c.centre_x = 32'h7fffffff; c.centre_y = 32'h80000000; c.centre_z = 32'h7fffffff;
      c.radius_x = 32'h7fffffff; c.radius_y = 32'h80000000;
      c.angle_origin = 32'h80000000; c.sweep_angle = 32'h7fffffff;
      c.segment_count = 6'd63;
      c.radius_delta = 32'h7fffffff; c.height_delta = 32'h7fffffff;
      pending_cmds.push_back(c);
      c.centre_x = 32'h80000000; c.centre_y = 32'h7fffffff; c.centre_z = 32'h80000000;
      c.radius_x = 32'h80000000; c.radius_y = 32'h7fffffff;
      c.angle_origin = 32'h7fffffff; c.sweep_angle = 32'h80000000;
      c.segment_count = 6'd2;
      c.radius_delta = 32'h80000000; c.height_delta = 32'h80000000;
      pending_cmds.push_back(c);
      // helix with truncating divisions of odd totals
      c = '0;
      c.radius_x = 32'h0005_0000; c.radius_y = 32'h0005_0000;
      c.sweep_angle = -32'sd7; c.segment_count = 6'd5;
      c.radius_delta = -32'sd13; c.height_delta = 32'sd17;
      pending_cmds.push_back(c);

      // burst with no idling, the receiver holding off at its start
      no_idle = 1'b1;
      for (int i = 0; i < N_BURST; i++) pending_cmds.push_back(rand_cmd());
      wait (pending_cmds.size() == 0);
      no_idle = 1'b0;

      for (int i = 0; i < N_RAND; i++) pending_cmds.push_back(rand_cmd());
      wait (pending_cmds.size() == 0);
      @(posedge clock);
      while (req.valid) @(posedge clock);
      stim_done = 1'b1;
   end

   // end of run: drain, settle, decide
   initial begin
      wait (stim_done);
      while (expected_points.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // timeout well beyond the slowest correct run
   initial begin
      #100ms;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+src
src/asei_pkg.sv
src/asei_stream_if.sv
src/asei_cordic.sv
src/asei_divider.sv
src/arc_spiral_ellipse_interpolator_top.sv
src/asei_checker.sv
dv/tb_arc_spiral_ellipse_interpolator_top.sv
